@@ rtl/upd_pkg.sv @@
`timescale 1ns / 1ps
package upd_pkg;

	// Largest count the design may report; the output field is 16 bits wide.
	localparam longint COUNT_MAX = 65535;
	localparam int CNT_W = 16;
	localparam logic [CNT_W-1:0] CNT_LIMIT =
		(COUNT_MAX < 65535) ? CNT_W'(COUNT_MAX) : {CNT_W{1'b1}};

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Escape phase codes.
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_PCT  = 2'd1;
	localparam logic [1:0] PH_DIG  = 2'd2;

	// Queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QLVL_W = $clog2(QDEPTH + 1);

	// Bytes that one input item produces, in output order.
	typedef struct packed {
		logic [1:0]      n;
		logic [2:0][7:0] bytes;
		logic            last;
	} grp_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QLVL_W-1:0] level;
	} q_stat_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if (c inside {[8'h30:8'h39]}) begin
			v = c - 8'h30;
		end else if (c inside {[8'h41:8'h46]}) begin
			v = c - 8'h37;
		end else if (c inside {[8'h61:8'h66]}) begin
			v = c - 8'h57;
		end
		return v[3:0];
	endfunction

endpackage

@@ rtl/upd_in_if.sv @@
`timescale 1ns / 1ps
interface upd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

@@ rtl/upd_out_if.sv @@
`timescale 1ns / 1ps
interface upd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        out_last;
	logic [15:0] out_count;

	modport source (output valid, output out_byte, output out_last, output out_count,
		input ready);
	modport sink (input valid, input out_byte, input out_last, input out_count,
		output ready);
endinterface

@@ rtl/upd_front.sv @@
`timescale 1ns / 1ps
module upd_front (
	input  logic            clk,
	input  logic            arst_n,
	upd_in_if.sink          rx,
	input  upd_pkg::q_stat_t q_stat,
	output logic            push,
	output upd_pkg::grp_t   push_grp
);
	import upd_pkg::*;

	logic [1:0]      phase_q;
	logic [7:0]      held_q;
	logic [1:0]      phase_d;
	logic [7:0]      held_d;
	logic [2:0][7:0] slot;
	logic [1:0]      k;
	logic            pl_emit;
	logic [7:0]      pl_val;
	logic            hx;
	logic            xfer;

	assign rx.ready = !q_stat.full;
	assign xfer = rx.valid && rx.ready;
	assign hx = is_hex(rx.in_byte);

	// A byte with no escape pending: '%' opens an escape, '+' becomes a space.
	assign pl_emit = (rx.in_byte != CH_PCT);
	assign pl_val = (rx.in_byte == CH_PLUS) ? CH_SPACE : rx.in_byte;

	always_comb begin
		slot = '0;
		k = 2'd0;
		phase_d = PH_IDLE;
		held_d = held_q;
		case (phase_q)
			PH_PCT: begin
				if (hx) begin
					phase_d = PH_DIG;
					held_d = rx.in_byte;
				end else begin
					slot[0] = CH_PCT;
					k = 2'd1;
					if (pl_emit) begin
						slot[1] = pl_val;
						k = 2'd2;
					end else begin
						phase_d = PH_PCT;
					end
				end
			end
			PH_DIG: begin
				if (hx) begin
					slot[0] = {hex_val(held_q), hex_val(rx.in_byte)};
					k = 2'd1;
				end else begin
					slot[0] = CH_PCT;
					slot[1] = held_q;
					k = 2'd2;
					if (pl_emit) begin
						slot[2] = pl_val;
						k = 2'd3;
					end else begin
						phase_d = PH_PCT;
					end
				end
			end
			default: begin
				if (pl_emit) begin
					slot[0] = pl_val;
					k = 2'd1;
				end else begin
					phase_d = PH_PCT;
				end
			end
		endcase

		// At the end of a string any partial escape goes out literally.
		if (rx.in_last) begin
			if (phase_d == PH_DIG) begin
				slot[0] = CH_PCT;
				slot[1] = held_d;
				k = 2'd2;
			end else if (phase_d == PH_PCT) begin
				slot[k] = CH_PCT;
				k = k + 2'd1;
			end
			phase_d = PH_IDLE;
			held_d = 8'h00;
		end
	end

	assign push = xfer && (k != 2'd0);
	assign push_grp = '{n: k, bytes: slot, last: rx.in_last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q <= 8'h00;
		end else if (xfer) begin
			phase_q <= phase_d;
			held_q <= held_d;
		end
	end

endmodule

@@ rtl/upd_queue.sv @@
`timescale 1ns / 1ps
module upd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  upd_pkg::grp_t    push_grp,
	input  logic             pop,
	output upd_pkg::grp_t    head,
	output upd_pkg::q_stat_t q_stat
);
	import upd_pkg::*;

	grp_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QLVL_W-1:0] level_q;
	logic              do_push;
	logic              do_pop;

	assign q_stat.level = level_q;
	assign q_stat.empty = (level_q == '0);
	assign q_stat.full = (level_q == QLVL_W'(QDEPTH));
	assign do_push = push && !q_stat.full;
	assign do_pop = pop && !q_stat.empty;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/upd_back.sv @@
`timescale 1ns / 1ps
module upd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  upd_pkg::grp_t    head,
	input  upd_pkg::q_stat_t q_stat,
	output logic             pop,
	upd_out_if.source        tx
);
	import upd_pkg::*;

	logic [1:0]       sel_q;
	logic [CNT_W-1:0] cnt_q;
	logic             vld_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic [CNT_W-1:0] count_q;
	logic             adv;
	logic             final_slot;
	logic             last_d;
	logic [CNT_W-1:0] cnt_inc;

	assign tx.valid = vld_q;
	assign tx.out_byte = byte_q;
	assign tx.out_last = last_q;
	assign tx.out_count = count_q;

	// The output register takes a new byte whenever the queue holds one and the register is empty or being drained.
	assign adv = !q_stat.empty && (!vld_q || tx.ready);
	assign final_slot = (sel_q == head.n - 2'd1);
	assign pop = adv && final_slot;
	assign last_d = head.last && final_slot;
	assign cnt_inc = (cnt_q == CNT_LIMIT) ? cnt_q : cnt_q + 1'b1;

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q <= head.bytes[sel_q];
			last_q <= last_d;
			count_q <= cnt_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			sel_q <= 2'd0;
			cnt_q <= '0;
		end else begin
			if (adv) begin
				vld_q <= 1'b1;
				sel_q <= final_slot ? 2'd0 : sel_q + 2'd1;
				cnt_q <= last_d ? '0 : cnt_inc;
			end else if (tx.ready) begin
				vld_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/url_percent_decoder_top.sv @@
`timescale 1ns / 1ps
// Streaming URL form decoder. Raw bytes enter on rx, one per transfer, with in_last on the
// final byte of a string; decoded bytes leave on tx with out_last and a saturating running
// count. The front end accepts one byte per cycle while the queue is not full and resolves
// escapes in that cycle, so input never waits on a partial escape. The back end sends one
// decoded byte per cycle from a four-entry queue while tx.ready holds: an ordinary byte or
// a completed escape yields one output byte, a broken escape or end-of-string flush one to
// three. Bursts are absorbed by the queue, and rx.ready drops only when it is full.
module url_percent_decoder_top (
	input  logic      clk,
	input  logic      arst_n,
	upd_in_if.sink    rx,
	upd_out_if.source tx
);
	import upd_pkg::*;

	logic    push;
	logic    pop;
	grp_t    push_grp;
	grp_t    head;
	q_stat_t q_stat;

	upd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.q_stat   (q_stat),
		.push     (push),
		.push_grp (push_grp)
	);

	upd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	upd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.tx     (tx)
	);

`ifndef SYNTHESIS
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.level <= QLVL_W'(QDEPTH))
		else $error("queue level exceeds its depth");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !q_stat.empty)
		else $error("queue empty right after a push");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid |-> (tx.out_count != '0))
		else $error("decoded byte carries a zero count");
`endif

endmodule

@@ bench/url_percent_decoder_checker.sv @@
`timescale 1ns / 1ps
module url_percent_decoder_checker
	import upd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	upd_in_if    rx,
	upd_out_if   tx,
	output int   mismatches,
	output int   pending,
	output int   decoded
);

	typedef struct {
		logic [7:0]  data;
		logic        last;
		logic [15:0] count;
	} decoded_t;

	decoded_t    decoded_q[$];
	logic [1:0]  phase;
	logic [7:0]  held;
	logic [15:0] count;

	function automatic logic hex_digit(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	// Letters A-F and a-f both have a low nibble of 1 to 6.
	function automatic logic [3:0] nibble_value(input logic [7:0] c);
		if (c <= 8'h39) begin
			return c[3:0];
		end
		return c[3:0] + 4'd9;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		decoded_t d;
		if (count != CNT_LIMIT) begin
			count = count + 16'd1;
		end
		d.data = b;
		d.last = 1'b0;
		d.count = count;
		decoded_q = {decoded_q, d};
	endtask

	task automatic take_plain(input logic [7:0] b);
		if (b == CH_PCT) begin
			phase = PH_PCT;
		end else if (b == CH_PLUS) begin
			push_byte(CH_SPACE);
		end else begin
			push_byte(b);
		end
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic last);
		int n_prior;
		n_prior = decoded_q.size();
		case (phase)
			PH_PCT: begin
				if (hex_digit(b)) begin
					phase = PH_DIG;
					held = b;
				end else begin
					phase = PH_IDLE;
					push_byte(CH_PCT);
					take_plain(b);
				end
			end
			PH_DIG: begin
				phase = PH_IDLE;
				if (hex_digit(b)) begin
					push_byte({nibble_value(held), nibble_value(b)});
				end else begin
					push_byte(CH_PCT);
					push_byte(held);
					take_plain(b);
				end
			end
			default: begin
				phase = PH_IDLE;
				take_plain(b);
			end
		endcase
		if (last) begin
			// Whatever is left of an escape goes out literally.
			if (phase == PH_PCT) begin
				push_byte(CH_PCT);
			end else if (phase == PH_DIG) begin
				push_byte(CH_PCT);
				push_byte(held);
			end
			if (decoded_q.size() > n_prior) begin
				decoded_q[decoded_q.size() - 1].last = 1'b1;
			end
			phase = PH_IDLE;
			held = 8'h00;
			count = 16'd0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		if (!arst_n) begin
			phase = PH_IDLE;
			held = 8'h00;
			count = 16'd0;
			decoded_q.delete();
			mismatches = 0;
			decoded = 0;
			pending <= 0;
		end else begin
			// Predict first so that a same-cycle result finds its expectation.
			if (rx.valid && rx.ready) begin
				decode_byte(rx.in_byte, rx.in_last);
			end
			if (tx.valid && tx.ready) begin
				if (decoded_q.size() == 0) begin
					$error("out_byte %h arrived with nothing expected", tx.out_byte);
					mismatches++;
				end else begin
					want = decoded_q.pop_front();
					decoded++;
					if (tx.out_byte !== want.data) begin
						$error("out_byte: expected %h, actual %h", want.data, tx.out_byte);
						mismatches++;
					end
					if (tx.out_last !== want.last) begin
						$error("out_last: expected %b, actual %b", want.last, tx.out_last);
						mismatches++;
					end
					if (tx.out_count !== want.count) begin
						$error("out_count: expected %0d, actual %0d", want.count,
							tx.out_count);
						mismatches++;
					end
				end
			end
			pending <= decoded_q.size();
		end
	end

endmodule

@@ bench/url_percent_decoder_top_tb.sv @@
`timescale 1ns / 1ps
module url_percent_decoder_top_tb;
	import upd_pkg::*;

	localparam int LONG_HOLD = 150;
	localparam int QUIET_LIMIT = 4000;
	localparam int RANDOM_BYTES = 300;
	localparam logic [7:0] NEAR_HEX [6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	upd_in_if  rx_ch ();
	upd_out_if tx_ch ();

	int mismatches;
	int pending;
	int decoded;
	int n_bytes = 0;
	int n_strings = 0;
	int quiet = 0;
	bit gappy = 1'b0;
	bit hold_req = 1'b0;
	bit hold_served = 1'b0;

	url_percent_decoder_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch)
	);

	url_percent_decoder_checker decode_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx_ch),
		.tx         (tx_ch),
		.mismatches (mismatches),
		.pending    (pending),
		.decoded    (decoded)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Nothing moving on either channel for too long means the block hung.
	always @(posedge clk) begin
		if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready)) begin
			quiet <= 0;
		end else if (arst_n) begin
			quiet <= quiet + 1;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("FAIL url_percent_decoder_top");
			$finish;
		end
	end

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	function automatic logic [7:0] hex_char(input int v);
		if (v < 10) begin
			return 8'(8'h30 + v);
		end
		return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
	endfunction

	function automatic logic [7:0] any_but_pct();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		return (b == CH_PCT) ? CH_PLUS : b;
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 9))
			0, 1, 2: return CH_PCT;
			3, 4, 5: return hex_char($urandom_range(0, 15));
			6:       return CH_PLUS;
			7:       return NEAR_HEX[$urandom_range(0, 5)];
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Receiver: random stalls while gappy, plus one long hold-off on request.
	initial begin
		tx_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_served) begin
				tx_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_served <= 1'b1;
			end else if (!gappy || $urandom_range(0, 3) != 0) begin
				tx_ch.ready <= 1'b1;
			end else begin
				tx_ch.ready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
			end
		end
	end

	// Valid is left high after a transfer; a gap or a pause lowers it.
	task automatic send_item(input logic [7:0] b, input logic last);
		if (gappy && $urandom_range(0, 2) == 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.in_byte <= b;
		rx_ch.in_last <= last;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		n_bytes++;
		if (last) begin
			n_strings++;
		end
	endtask

	task automatic send_text(input string s, input logic last_at_end);
		for (int i = 0; i < s.len(); i++) begin
			send_item(s[i], last_at_end && i == s.len() - 1);
		end
	endtask

	task automatic wait_drained();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic send_random_string();
		logic [7:0] text[$];
		int pieces;
		pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
		if ($urandom_range(0, 3) != 0) begin
			repeat (pieces) begin
				case ($urandom_range(0, 4))
					0: text = {text, CH_PLUS};
					1, 2: begin
						text = {text, CH_PCT};
						text = {text, hex_char($urandom_range(0, 15))};
						text = {text, hex_char($urandom_range(0, 15))};
					end
					default: text = {text, any_but_pct()};
				endcase
			end
		end else begin
			repeat (pieces) text = {text, noise_byte()};
		end
		foreach (text[i]) begin
			send_item(text[i], i == text.size() - 1);
		end
	endtask

	initial begin
		int start;
		bit hold_done;
		bit drain_done;
		hold_done = 1'b0;
		drain_done = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.in_byte = 8'h00;
		rx_ch.in_last = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: plus sign, escapes of both cases, broken escapes, byte extremes,
		// and flushes at end of string.
		send_text("+", 1'b0);
		send_text("%41", 1'b0);
		send_text("%fF", 1'b0);
		send_text("%00", 1'b0);
		send_text("%G", 1'b0);
		send_text("%a+", 1'b0);
		send_text("%%25", 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_text("%", 1'b1);
		send_text("%B", 1'b1);
		send_text("%7e", 1'b1);

		start = n_bytes;
		while (n_bytes - start < RANDOM_BYTES) begin
			if (!hold_done && n_bytes - start >= 100) begin
				// Keep offering bytes while the receiver holds off, so the queue fills.
				hold_done = 1'b1;
				gappy <= 1'b0;
				hold_req <= 1'b1;
				for (int i = 0; i < 30; i++) begin
					send_item(any_but_pct(), i == 29);
				end
			end else if (!drain_done && n_bytes - start >= 200) begin
				drain_done = 1'b1;
				wait_drained();
			end else begin
				gappy <= ($urandom_range(0, 4) != 0);
				send_random_string();
			end
		end

		gappy <= 1'b0;
		send_text("%4", 1'b1);

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Drove %0d encoded bytes in %0d strings; %0d decoded bytes were checked.",
			n_bytes, n_strings, decoded);
		$display("Covered escapes, broken escapes, end flushes, a full queue and a drain.");
		if (mismatches == 0 && pending == 0) begin
			$display("PASS url_percent_decoder_top");
		end else begin
			if (pending != 0) begin
				$error("%0d decoded bytes never arrived", pending);
			end
			$display("FAIL url_percent_decoder_top");
		end
		$finish;
	end

endmodule
